### hdl/limb_darkened_disk_fraction_assert.svh
// Assertion macros for the limb-darkened disk block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef LIMB_DARKENED_DISK_FRACTION_ASSERT_SVH
`define LIMB_DARKENED_DISK_FRACTION_ASSERT_SVH

// same-cycle implication
`define LDD_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define LDD_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/ldd_pkg.sv
// Shared constants, types and coefficient tables for the limb-darkened disk block.
// No dependencies.
package ldd_pkg;

    localparam int QBITS         = 30;
    localparam int MU_W          = QBITS + 1;
    localparam int ACC_W         = 36;
    localparam int SQ_REM_W      = 35;
    localparam int LO_W          = 18;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_TERMS_DEF = 6;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [MU_W-1:0]         t_mu;
    typedef logic [1:0]              t_model;

    localparam t_mu Q_ONE = t_mu'(1) << QBITS;

    localparam t_model MODEL_QUAD    = 2'd0;
    localparam t_model MODEL_QUINT_A = 2'd1;
    localparam t_model MODEL_QUINT_B = 2'd2;
    localparam t_model MODEL_UNIFORM = 2'd3;
    localparam t_model MODEL_RESET   = MODEL_QUINT_B;

    // Signed Q6.30 polynomial coefficients, lowest power first
    localparam t_acc C_QUAD [0:5] = '{
        36'sd468151435, 36'sd773094113, -36'sd171798692, 36'sd0, 36'sd0, 36'sd0};
    localparam t_acc C_QA [0:5] = '{
        36'sd327544943, 36'sd1214648964, -36'sd844004023,
        36'sd435509684, 36'sd24663850, -36'sd84610856};
    localparam t_acc C_QB [0:5] = '{
        36'sd304856779, 36'sd1469909607, -36'sd1889764135,
        36'sd2385360412, -36'sd1675831814, 36'sd479210976};

    // c_i / (i + 2), rounded half away from zero
    localparam t_acc D_QUAD [0:5] = '{
        36'sd234075718, 36'sd257698038, -36'sd42949673, 36'sd0, 36'sd0, 36'sd0};
    localparam t_acc D_QA [0:5] = '{
        36'sd163772472, 36'sd404882988, -36'sd211001006,
        36'sd87101937, 36'sd4110642, -36'sd12087265};
    localparam t_acc D_QB [0:5] = '{
        36'sd152428390, 36'sd489969869, -36'sd472441034,
        36'sd477072082, -36'sd279305302, 36'sd68458711};

    function automatic t_acc coef_of(input t_model model, input logic [2:0] idx);
        t_acc c;
        case (model)
            MODEL_QUAD:    c = C_QUAD[idx];
            MODEL_QUINT_A: c = C_QA[idx];
            MODEL_QUINT_B: c = C_QB[idx];
            default:       c = '0;
        endcase
        return c;
    endfunction

    function automatic t_acc dcoef_of(input t_model model, input logic [2:0] idx);
        t_acc d;
        case (model)
            MODEL_QUAD:    d = D_QUAD[idx];
            MODEL_QUINT_A: d = D_QA[idx];
            MODEL_QUINT_B: d = D_QB[idx];
            default:       d = '0;
        endcase
        return d;
    endfunction

    // total disk light: sum of the used d_i
    function automatic t_acc disk_i0(input t_model model, input logic [2:0] nterms);
        t_acc s;
        s = '0;
        for (int i = 0; i < 6; i++) begin
            if (3'(i) < nterms) begin
                s = s + dcoef_of(model, 3'(i));
            end
        end
        return s;
    endfunction

endpackage

### hdl/ldd_if.sv
// Valid/ready channel interfaces for the limb-darkened disk block.
// No dependencies.
interface ldd_in_if #(parameter int W = 17);
    logic         valid;
    logic         ready;
    logic [W-1:0] radius;
    modport source (output valid, output radius, input ready);
    modport sink   (input valid, input radius, output ready);
endinterface

interface ldd_out_if #(parameter int W = 17);
    logic         valid;
    logic         ready;
    logic [W-1:0] surface_intensity;
    logic [W-1:0] enclosed_fraction;
    modport source (output valid, output surface_intensity, output enclosed_fraction,
                    input ready);
    modport sink   (input valid, input surface_intensity, input enclosed_fraction,
                    output ready);
endinterface

### hdl/ldd_sqrt_cell.sv
// One digit step of the restoring square root of mu2 * 2^30.
// Depends on ldd_pkg.
module ldd_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ldd_pkg::SQ_REM_W-1:0]    i_rem,
    input  ldd_pkg::t_mu                    i_root,
    input  ldd_pkg::t_mu                    i_mu2,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ldd_pkg::SQ_REM_W-1:0]    o_rem,
    output ldd_pkg::t_mu                    o_root,
    output ldd_pkg::t_mu                    o_mu2
);
    localparam int VW = ldd_pkg::MU_W + ldd_pkg::QBITS + 1;
    localparam int RW = ldd_pkg::SQ_REM_W;

    logic [VW-1:0] radicand;
    logic [RW-1:0] cur, trial, n_rem;
    logic          ge;
    ldd_pkg::t_mu  n_root;
    logic          r_valid;
    logic [RW-1:0] r_rem;
    ldd_pkg::t_mu  r_root, r_mu2;

    always_comb begin
        radicand = {1'b0, i_mu2, ldd_pkg::QBITS'(0)};
        cur      = {i_rem[RW-3:0], radicand[2*K+1 -: 2]};
        trial    = RW'({i_root, 2'b01});
        ge       = cur >= trial;
        n_rem    = ge ? cur - trial : cur;
        n_root   = {i_root[ldd_pkg::MU_W-2:0], ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_mu2  <= i_mu2;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_mu2   = r_mu2;
endmodule

### hdl/ldd_horner_cell.sv
// Horner step acc * mul + add, Q30 product rounded half away from zero.
// Two register stages: split partial products, then sum and add. Depends on ldd_pkg.
module ldd_horner_cell #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ldd_pkg::t_acc     i_acc,
    input  ldd_pkg::t_mu      i_mul,
    input  ldd_pkg::t_acc     i_add,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output ldd_pkg::t_acc     o_acc,
    output logic [SIDE_W-1:0] o_side
);
    localparam int AW   = ldd_pkg::ACC_W;
    localparam int LW   = ldd_pkg::LO_W;
    localparam int HW   = AW - LW;
    localparam int PW   = AW + ldd_pkg::MU_W;
    localparam logic [PW-1:0] RND = PW'(1) << (ldd_pkg::QBITS - 1);

    logic [AW-1:0]                 mag_in;
    logic [LW+ldd_pkg::MU_W-1:0]   n_pl;
    logic [HW+ldd_pkg::MU_W-1:0]   n_ph;
    logic [PW-1:0]                 psum;
    ldd_pkg::t_acc                 pmag, n_acc;
    logic                          ready2;

    logic                          r1_valid, r1_neg;
    logic [LW+ldd_pkg::MU_W-1:0]   r1_pl;
    logic [HW+ldd_pkg::MU_W-1:0]   r1_ph;
    ldd_pkg::t_acc                 r1_add;
    logic [SIDE_W-1:0]             r1_side;
    logic                          r2_valid;
    ldd_pkg::t_acc                 r2_acc;
    logic [SIDE_W-1:0]             r2_side;

    always_comb begin
        mag_in = i_acc[AW-1] ? AW'(-i_acc) : AW'(i_acc);
        n_pl   = mag_in[LW-1:0] * i_mul;
        n_ph   = mag_in[AW-1:LW] * i_mul;
        psum   = (PW'(r1_ph) << LW) + PW'(r1_pl) + RND;
        pmag   = ldd_pkg::t_acc'(psum >> ldd_pkg::QBITS);
        n_acc  = (r1_neg ? -pmag : pmag) + r1_add;
    end

    assign ready2  = !r2_valid || i_ready;
    assign o_ready = !r1_valid || ready2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_valid <= i_valid;
            end
            if (ready2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r1_neg  <= i_acc[AW-1];
            r1_pl   <= n_pl;
            r1_ph   <= n_ph;
            r1_add  <= i_add;
            r1_side <= i_side;
        end
        if (ready2 && r1_valid) begin
            r2_acc  <= n_acc;
            r2_side <= r1_side;
        end
    end

    assign o_valid = r2_valid;
    assign o_acc   = r2_acc;
    assign o_side  = r2_side;
endmodule

### hdl/ldd_div_cell.sv
// One quotient bit of a restoring division by the disk total.
// Depends on ldd_pkg.
module ldd_div_cell #(
    parameter int K      = 0,
    parameter int REM_W  = 53,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [REM_W-1:0]         i_rem,
    input  logic [ldd_pkg::ACC_W-1:0] i_den,
    input  logic [Q_W-1:0]           i_quo,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [REM_W-1:0]         o_rem,
    output logic [Q_W-1:0]           o_quo,
    output logic [SIDE_W-1:0]        o_side
);
    logic [REM_W-1:0]  sub, n_rem;
    logic [Q_W-1:0]    n_quo;
    logic              ge;
    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_quo;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        sub      = REM_W'(i_den) << K;
        ge       = i_rem >= sub;
        n_rem    = ge ? i_rem - sub : i_rem;
        n_quo    = i_quo;
        n_quo[K] = ge;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule

### hdl/limb_darkened_disk_fraction.sv
// Limb-darkened disk: surface brightness and enclosed light fraction per radius.
// Depends on ldd_pkg, ldd_if, ldd_sqrt_cell, ldd_horner_cell, ldd_div_cell.
//
// Input channel i_in carries radius (unsigned Q1.FRAC_BITS, clamped at 1.0).
// Output channel o_out carries surface_intensity and enclosed_fraction, both
// unsigned Q1.FRAC_BITS in [0, 1.0]; one result per input, in order.
// i_cfg_we / i_cfg_wdata write disk_model (0 quadratic, 1 and 2 quintic fits,
// 3 uniform); write it only while no transaction is in flight.
// Datapath: a squarer, QBITS+1 square-root digit cells, two Horner chains of
// NUM_TERMS-1 two-stage cells, one two-stage cell for the mu2 product,
// FRAC_BITS+1 restoring division cells and an output register.
// Throughput: one transaction per cycle, limited by nothing but the output side.
// Each cell holds its own valid bit and moves when the cell after it is empty or
// moving, so a stalled receiver fills the chain from the end while inputs are
// still taken until every cell is occupied.
// Reset clears all valid bits and sets disk_model to 2.
module limb_darkened_disk_fraction #(
    parameter int FRAC_BITS = ldd_pkg::FRAC_BITS_DEF,
    parameter int NUM_TERMS = ldd_pkg::NUM_TERMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_wdata,
    ldd_in_if.sink               i_in,
    ldd_out_if.source            o_out
);
    localparam int IO_W   = FRAC_BITS + 1;
    localparam int SH     = ldd_pkg::QBITS - FRAC_BITS;
    localparam int HALF   = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int HN     = NUM_TERMS - 1;
    localparam int NSQ    = ldd_pkg::QBITS + 1;
    localparam int MW     = ldd_pkg::MU_W;
    localparam int AW     = ldd_pkg::ACC_W;
    localparam int RW     = ldd_pkg::SQ_REM_W;
    localparam int REM_W  = AW + FRAC_BITS + 1;
    localparam int SQ_W   = 2 * IO_W;
    localparam int FULL_W = 2 * ldd_pkg::QBITS + 2;
    localparam logic [IO_W-1:0] IO_ONE = IO_W'(1) << FRAC_BITS;
    localparam int S1_W   = 2 * MW;
    localparam int S2_W   = AW + 2 * MW;
    localparam int S3_W   = AW + MW;
    localparam int S4_W   = IO_W + MW;

    ldd_pkg::t_model r_disk_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_model <= ldd_pkg::MODEL_RESET;
        end else if (i_cfg_we) begin
            r_disk_model <= i_cfg_wdata;
        end
    end

    // ---- front: clamp, square, 1 - r^2
    logic [IO_W-1:0]   rad;
    logic [SQ_W-1:0]   rsq;
    logic [FULL_W-1:0] rfull;
    logic [MW:0]       r2;
    ldd_pkg::t_mu      r2c, mu2_in;

    always_comb begin
        rad    = (i_in.radius > IO_ONE) ? IO_ONE : i_in.radius;
        rsq    = SQ_W'(rad) * SQ_W'(rad);
        rfull  = (FULL_W'(rsq) << (2 * SH)) + (FULL_W'(1) << (ldd_pkg::QBITS - 1));
        r2     = (MW + 1)'(rfull >> ldd_pkg::QBITS);
        r2c    = (r2 > (MW + 1)'(ldd_pkg::Q_ONE)) ? ldd_pkg::Q_ONE : MW'(r2);
        mu2_in = ldd_pkg::Q_ONE - r2c;
    end

    // ---- square root chain
    logic          s_valid [0:NSQ];
    logic          s_ready [0:NSQ];
    logic [RW-1:0] s_rem   [0:NSQ];
    ldd_pkg::t_mu  s_root  [0:NSQ];
    ldd_pkg::t_mu  s_mu2   [0:NSQ];

    assign s_valid[0]  = i_in.valid;
    assign i_in.ready  = s_ready[0];
    assign s_rem[0]    = '0;
    assign s_root[0]   = '0;
    assign s_mu2[0]    = mu2_in;

    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        ldd_sqrt_cell #(.K(ldd_pkg::QBITS - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[j]),
            .o_ready (s_ready[j]),
            .i_rem   (s_rem[j]),
            .i_root  (s_root[j]),
            .i_mu2   (s_mu2[j]),
            .o_valid (s_valid[j+1]),
            .i_ready (s_ready[j+1]),
            .o_rem   (s_rem[j+1]),
            .o_root  (s_root[j+1]),
            .o_mu2   (s_mu2[j+1])
        );
    end

    // ---- brightness polynomial, side = {mu2, mu}
    logic            a_valid [0:HN];
    logic            a_ready [0:HN];
    ldd_pkg::t_acc   a_acc   [0:HN];
    logic [S1_W-1:0] a_side  [0:HN];

    assign a_valid[0]      = s_valid[NSQ];
    assign s_ready[NSQ]    = a_ready[0];
    assign a_acc[0]        = ldd_pkg::coef_of(r_disk_model, 3'(NUM_TERMS - 1));
    assign a_side[0]       = {s_mu2[NSQ], s_root[NSQ]};

    for (genvar j = 0; j < HN; j++) begin : g_poly_i
        ldd_horner_cell #(.SIDE_W(S1_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (a_valid[j]),
            .o_ready (a_ready[j]),
            .i_acc   (a_acc[j]),
            .i_mul   (a_side[j][MW-1:0]),
            .i_add   (ldd_pkg::coef_of(r_disk_model, 3'(NUM_TERMS - 2 - j))),
            .i_side  (a_side[j]),
            .o_valid (a_valid[j+1]),
            .i_ready (a_ready[j+1]),
            .o_acc   (a_acc[j+1]),
            .o_side  (a_side[j+1])
        );
    end

    // ---- enclosed-light polynomial, side = {acc_i, mu2, mu}
    logic            b_valid [0:HN];
    logic            b_ready [0:HN];
    ldd_pkg::t_acc   b_acc   [0:HN];
    logic [S2_W-1:0] b_side  [0:HN];

    assign b_valid[0]  = a_valid[HN];
    assign a_ready[HN] = b_ready[0];
    assign b_acc[0]    = ldd_pkg::dcoef_of(r_disk_model, 3'(NUM_TERMS - 1));
    assign b_side[0]   = {a_acc[HN], a_side[HN]};

    for (genvar j = 0; j < HN; j++) begin : g_poly_d
        ldd_horner_cell #(.SIDE_W(S2_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (b_valid[j]),
            .o_ready (b_ready[j]),
            .i_acc   (b_acc[j]),
            .i_mul   (b_side[j][MW-1:0]),
            .i_add   (ldd_pkg::dcoef_of(r_disk_model, 3'(NUM_TERMS - 2 - j))),
            .i_side  (b_side[j]),
            .o_valid (b_valid[j+1]),
            .i_ready (b_ready[j+1]),
            .o_acc   (b_acc[j+1]),
            .o_side  (b_side[j+1])
        );
    end

    // ---- t = acc_d * mu2, side = {acc_i, mu2}
    logic            t_valid, t_ready;
    ldd_pkg::t_acc   t_val;
    logic [S3_W-1:0] t_side;

    ldd_horner_cell #(.SIDE_W(S3_W)) u_mu2_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid[HN]),
        .o_ready (b_ready[HN]),
        .i_acc   (b_acc[HN]),
        .i_mul   (b_side[HN][2*MW-1:MW]),
        .i_add   ('0),
        .i_side  (b_side[HN][S2_W-1:MW]),
        .o_valid (t_valid),
        .i_ready (t_ready),
        .o_acc   (t_val),
        .o_side  (t_side)
    );

    // ---- division setup and brightness rounding
    ldd_pkg::t_acc     i0, t_acc_i, num;
    logic [MW:0]       surf_q30;
    logic [IO_W-1:0]   surf_rnd, surf_io;
    logic [REM_W-1:0]  dividend;

    always_comb begin
        i0      = ldd_pkg::disk_i0(r_disk_model, 3'(NUM_TERMS));
        t_acc_i = t_side[S3_W-1:MW];
        num     = i0 - t_val;
        if (num < 0) begin
            num = '0;
        end
        if (num > i0) begin
            num = i0;
        end
        dividend = (REM_W'(num) << FRAC_BITS) + REM_W'(i0 >>> 1);

        if (t_acc_i < 0) begin
            surf_q30 = '0;
        end else if (t_acc_i > AW'(ldd_pkg::Q_ONE)) begin
            surf_q30 = (MW + 1)'(ldd_pkg::Q_ONE);
        end else begin
            surf_q30 = (MW + 1)'(t_acc_i);
        end
        surf_rnd = IO_W'((surf_q30 + (MW + 1)'(HALF)) >> SH);
        surf_io  = (surf_rnd > IO_ONE) ? IO_ONE : surf_rnd;
    end

    // ---- division chain, side = {surface, mu2}
    logic             d_valid [0:IO_W];
    logic             d_ready [0:IO_W];
    logic [REM_W-1:0] d_rem   [0:IO_W];
    logic [IO_W-1:0]  d_quo   [0:IO_W];
    logic [S4_W-1:0]  d_side  [0:IO_W];

    assign d_valid[0] = t_valid;
    assign t_ready    = d_ready[0];
    assign d_rem[0]   = dividend;
    assign d_quo[0]   = '0;
    assign d_side[0]  = {surf_io, t_side[MW-1:0]};

    for (genvar j = 0; j < IO_W; j++) begin : g_div
        ldd_div_cell #(
            .K      (FRAC_BITS - j),
            .REM_W  (REM_W),
            .Q_W    (IO_W),
            .SIDE_W (S4_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[j]),
            .o_ready (d_ready[j]),
            .i_rem   (d_rem[j]),
            .i_den   (AW'(i0)),
            .i_quo   (d_quo[j]),
            .i_side  (d_side[j]),
            .o_valid (d_valid[j+1]),
            .i_ready (d_ready[j+1]),
            .o_rem   (d_rem[j+1]),
            .o_quo   (d_quo[j+1]),
            .o_side  (d_side[j+1])
        );
    end

    // ---- output register
    ldd_pkg::t_mu    fin_mu2;
    logic [IO_W-1:0] n_surf, n_frac, uni_frac, div_q;
    logic            out_ready;
    logic            r_out_valid;
    logic [IO_W-1:0] r_surf, r_frac;

    always_comb begin
        fin_mu2  = d_side[IO_W][MW-1:0];
        div_q    = d_quo[IO_W];
        uni_frac = IO_W'((ldd_pkg::Q_ONE - fin_mu2) >> SH);
        if (r_disk_model == ldd_pkg::MODEL_UNIFORM) begin
            n_surf = IO_ONE;
            n_frac = (uni_frac > IO_ONE) ? IO_ONE : uni_frac;
        end else begin
            n_surf = d_side[IO_W][S4_W-1:MW];
            if (i0 <= 0) begin
                n_frac = IO_ONE;
            end else begin
                n_frac = (div_q > IO_ONE) ? IO_ONE : div_q;
            end
        end
    end

    assign out_ready     = !r_out_valid || o_out.ready;
    assign d_ready[IO_W] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= d_valid[IO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && d_valid[IO_W]) begin
            r_surf <= n_surf;
            r_frac <= n_frac;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.surface_intensity = r_surf;
    assign o_out.enclosed_fraction = r_frac;

`include "limb_darkened_disk_fraction_assert.svh"

    `LDD_ASSERT_IMP(a_surf_range, o_out.valid, o_out.surface_intensity <= IO_ONE, "brightness above 1.0")
    `LDD_ASSERT_IMP(a_frac_range, o_out.valid, o_out.enclosed_fraction <= IO_ONE, "fraction above 1.0")
    `LDD_ASSERT_IMP(a_uniform_surf, o_out.valid && r_disk_model == ldd_pkg::MODEL_UNIFORM, o_out.surface_intensity == IO_ONE, "uniform disk brightness not 1.0")
    `LDD_ASSERT_NXT(a_front_load, i_in.valid && i_in.ready, s_valid[1], "accepted radius did not enter the root chain")

endmodule
